/* rtl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;
  localparam int unsigned QCW    = 2;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [5:0] s0;
    logic [5:0] s1;
    logic [5:0] s2;
    logic [5:0] s3;
    logic [1:0] npad;
    logic       last;
  } grp_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] w;
    logic [6:0] c;
    w = {1'b0, v};
    if (v < 6'd26) begin
      c = 7'h41 + w;
    end else if (v < 6'd52) begin
      c = 7'h61 + w - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + w - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Gathers bytes into groups of three and hands finished groups, as sextets
// with a pad count, to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_end_of_message,
  output logic               push,
  output b64e_pkg::grp_t     push_grp,
  input  wire logic          q_full
);

  b64e_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      pend_r, pend_nxt;
  logic             accept;
  logic [7:0]       b;
  logic [7:0]       b0;
  logic [7:0]       b1;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data_byte;
  assign b0       = pend_r[15:8];
  assign b1       = pend_r[7:0];

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    push      = 1'b0;
    push_grp  = '0;
    case (phase_r)
      b64e_pkg::PH_ONE: begin
        push_grp.s0   = b0[7:2];
        push_grp.s1   = {b0[1:0], b[7:4]};
        push_grp.s2   = {b[3:0], 2'b00};
        push_grp.npad = 2'd1;
        push_grp.last = 1'b1;
        if (accept) begin
          if (in_end_of_message) begin
            push      = 1'b1;
            phase_nxt = b64e_pkg::PH_EMPTY;
            pend_nxt  = '0;
          end else begin
            phase_nxt = b64e_pkg::PH_TWO;
            pend_nxt  = {b0, b};
          end
        end
      end
      b64e_pkg::PH_TWO: begin
        push_grp.s0   = b0[7:2];
        push_grp.s1   = {b0[1:0], b1[7:4]};
        push_grp.s2   = {b1[3:0], b[7:6]};
        push_grp.s3   = b[5:0];
        push_grp.npad = 2'd0;
        push_grp.last = in_end_of_message;
        if (accept) begin
          push      = 1'b1;
          phase_nxt = b64e_pkg::PH_EMPTY;
          pend_nxt  = '0;
        end
      end
      default: begin
        push_grp.s0   = b[7:2];
        push_grp.s1   = {b[1:0], 4'b0000};
        push_grp.npad = 2'd2;
        push_grp.last = 1'b1;
        if (accept) begin
          if (in_end_of_message) begin
            push      = 1'b1;
            phase_nxt = b64e_pkg::PH_EMPTY;
            pend_nxt  = '0;
          end else begin
            phase_nxt = b64e_pkg::PH_ONE;
            pend_nxt  = {b, 8'h00};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PH_EMPTY;
      pend_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of encoded groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire b64e_pkg::grp_t push_grp,
  input  wire logic           pop,
  output b64e_pkg::grp_t      head_grp,
  output logic                q_valid,
  output logic                q_full
);

  b64e_pkg::grp_t                  mem_r [b64e_pkg::QDEPTH];
  logic [b64e_pkg::QAW-1:0]        wptr_r, wptr_nxt;
  logic [b64e_pkg::QAW-1:0]        rptr_r, rptr_nxt;
  logic [b64e_pkg::QCW-1:0]        cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign q_full   = (cnt_r == b64e_pkg::QCW'(b64e_pkg::QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign head_grp = mem_r[rptr_r];
  assign do_push  = push && !q_full;
  assign do_pop   = pop && q_valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_grp;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= b64e_pkg::QCW'(b64e_pkg::QDEPTH))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("group pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("group popped from an empty queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with an empty count");

endmodule

`default_nettype wire

/* rtl/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Takes groups from the queue and sends their four characters out one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire b64e_pkg::grp_t head_grp,
  input  wire logic           q_valid,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [6:0]          out_char,
  output logic                out_last
);

  b64e_pkg::grp_t grp_r, grp_nxt;
  logic           busy_r, busy_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           ov_r, ov_nxt;
  logic [6:0]     oc_r, oc_nxt;
  logic           ol_r, ol_nxt;
  logic           load;
  logic           emit;
  logic           done;
  logic [5:0]     sext;
  logic [2:0]     padsum;

  assign load   = !ov_r || out_ready;
  assign emit   = load && busy_r;
  assign done   = emit && (idx_r == 2'd3);
  assign pop    = q_valid && (!busy_r || done);
  assign padsum = {1'b0, idx_r} + {1'b0, grp_r.npad};

  always_comb begin
    case (idx_r)
      2'd0:    sext = grp_r.s0;
      2'd1:    sext = grp_r.s1;
      2'd2:    sext = grp_r.s2;
      default: sext = grp_r.s3;
    endcase
  end

  always_comb begin
    grp_nxt  = grp_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    oc_nxt   = oc_r;
    ol_nxt   = ol_r;
    if (load) begin
      ov_nxt = busy_r;
    end
    if (emit) begin
      oc_nxt  = (padsum > 3'd3) ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(sext);
      ol_nxt  = grp_r.last && (idx_r == 2'd3);
      idx_nxt = idx_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      grp_nxt  = head_grp;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (idx_r == 2'd0))
    else $error("character index moved while no group is held");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && idx_r != 2'd3) |=> !ol_r)
    else $error("last flag raised before the fourth character");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(oc_r) && $stable(ol_r)))
    else $error("output changed while stalled");

endmodule

`default_nettype wire

/* rtl/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Base64 encoder with '=' padding over a byte stream with end-of-message.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+------------------------------
//   in_     | input     | in_valid/in_ready   | in_data_byte, in_end_of_message
//   out_    | output    | out_valid/out_ready | out_char, out_last
//
// One byte is accepted per cycle while the two-entry group queue has room.
// Each finished group leaves as four characters, one per cycle while the
// output is not stalled, so the character output port sets the sustained
// rate. A completed group passes through the queue, the group register
// and the output register before its first character leaves. Synchronous
// reset empties the queue and clears the partial group. A stalled output
// holds its character, and input stalls only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char,
  output logic             out_last
);

  logic           push;
  logic           pop;
  logic           q_valid;
  logic           q_full;
  b64e_pkg::grp_t push_grp;
  b64e_pkg::grp_t head_grp;

  b64e_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .push              (push),
    .push_grp          (push_grp),
    .q_full            (q_full)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_grp  (head_grp),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 stream encoder. Directed messages and
// messages of random length and content are sent as bytes. Each accepted
// byte runs through an encoder model that queues the characters it should
// produce. Every character that leaves the block is compared with the
// oldest queued one. Sender and receiver idle at changing rates, and the
// bench drains the block completely between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } b64_out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } msg_byte_t;

  localparam logic [8*64-1:0] B64_TABLE =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       out_last;

  msg_byte_t  byte_q[$];
  b64_out_t   chars_expected[$];
  b64e_pkg::phase_t grp_phase = b64e_pkg::PH_EMPTY;
  logic [15:0] held_bytes = 16'h0000;
  bit         in_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         errors = 0;
  int         bytes_sent = 0;
  int         msgs_queued = 0;
  int         chars_checked = 0;

  base64_stream_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_last          (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    return B64_TABLE[8*(63 - int'(v)) +: 7];
  endfunction

  task automatic queue_char(input logic [6:0] ch, input logic last);
    b64_out_t c;
    c.ch = ch;
    c.last = last;
    chars_expected.push_back(c);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    case (grp_phase)
      b64e_pkg::PH_EMPTY: begin
        if (!eom) begin
          held_bytes = {b, 8'h00};
          grp_phase = b64e_pkg::PH_ONE;
        end else begin
          queue_char(sextet_char(b[7:2]), 1'b0);
          queue_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
          queue_char(b64e_pkg::PAD_CHAR, 1'b0);
          queue_char(b64e_pkg::PAD_CHAR, 1'b1);
          held_bytes = 16'h0000;
          grp_phase = b64e_pkg::PH_EMPTY;
        end
      end
      b64e_pkg::PH_ONE: begin
        if (!eom) begin
          held_bytes = {b0, b};
          grp_phase = b64e_pkg::PH_TWO;
        end else begin
          queue_char(sextet_char(b0[7:2]), 1'b0);
          queue_char(sextet_char({b0[1:0], b[7:4]}), 1'b0);
          queue_char(sextet_char({b[3:0], 2'b00}), 1'b0);
          queue_char(b64e_pkg::PAD_CHAR, 1'b1);
          held_bytes = 16'h0000;
          grp_phase = b64e_pkg::PH_EMPTY;
        end
      end
      default: begin
        queue_char(sextet_char(b0[7:2]), 1'b0);
        queue_char(sextet_char({b0[1:0], b1[7:4]}), 1'b0);
        queue_char(sextet_char({b1[3:0], b[7:6]}), 1'b0);
        queue_char(sextet_char(b[5:0]), eom);
        held_bytes = 16'h0000;
        grp_phase = b64e_pkg::PH_EMPTY;
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eom);
    msg_byte_t m;
    m.data = b;
    m.eom = eom;
    byte_q.push_back(m);
    if (eom) msgs_queued++;
  endtask

  task automatic random_messages(input int n_bytes);
    int count;
    int len;
    logic [7:0] b;
    count = 0;
    while (count < n_bytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(255));
        endcase
        push_byte(b, i == len - 1);
      end
      count += len;
    end
  endtask

  task automatic drain_block();
    while (byte_q.size() != 0 || in_valid || chars_expected.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    msg_byte_t m;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        m = byte_q.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= m.data;
        in_end_of_message <= m.eom;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    b64_out_t exp_c;
    if (rst_n && in_valid && in_ready) begin
      encode_byte(in_data_byte, in_end_of_message);
      in_taken = 1'b1;
      bytes_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (chars_expected.size() == 0) begin
        $display("%0t: unexpected word: char %h last %b", $time, out_char, out_last);
        errors++;
      end else begin
        exp_c = chars_expected.pop_front();
        chars_checked++;
        if (out_char !== exp_c.ch) begin
          $display("%0t: out_char mismatch: expected %h actual %h",
                   $time, exp_c.ch, out_char);
          errors++;
        end
        if (out_last !== exp_c.last) begin
          $display("%0t: out_last mismatch: expected %b actual %b",
                   $time, exp_c.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 84;
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b1);
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b1);
    random_messages(125);
    drain_block();

    send_idle_pct = 84;
    recv_idle_pct = 7;
    random_messages(125);
    drain_block();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_messages(125);
    drain_block();

    repeat (20) @(posedge clk);
    $display("Encoded %0d bytes in %0d messages; %0d characters checked, %0d errors.",
             bytes_sent, msgs_queued, chars_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d characters outstanding.", chars_expected.size());
    $display("status: fail");
    $finish;
  end

endmodule
